### hw/rtl/iss_pkg.sv
package iss_pkg;

    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [MODE_W-1:0] MODE_INSERT      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ        = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_APPEND      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE_LAST = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam logic [DATA_W-1:0] NO_VALUE = '1;

    // What every cell of the row does at each clock edge, relative to the target index.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_OPEN,
        CELL_CLOSE,
        CELL_LOAD
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [DATA_W-1:0]  value;
    } t_cell_cmd;

endpackage

### hw/rtl/iss_cell.sv
module iss_cell #(
    parameter int CW    = 5,
    parameter int INDEX = 0
) (
    input  logic                      i_clk,
    input  iss_pkg::t_cell_cmd        i_cmd,
    input  logic [CW-1:0]             i_target,
    input  logic [iss_pkg::DATA_W-1:0] i_left,
    input  logic [iss_pkg::DATA_W-1:0] i_right,
    output logic [iss_pkg::DATA_W-1:0] o_entry
);
    import iss_pkg::*;

    localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            CELL_OPEN: begin
                if (MY_INDEX == i_target) begin
                    n_entry = i_cmd.value;
                end else if (MY_INDEX > i_target) begin
                    n_entry = i_left;
                end
            end
            CELL_CLOSE: begin
                if (MY_INDEX >= i_target) begin
                    n_entry = i_right;
                end
            end
            CELL_LOAD: begin
                if (MY_INDEX == i_target) begin
                    n_entry = i_cmd.value;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

### hw/rtl/indexed_sequence_store_top.sv
// Channel   Ports                                       Handshake
// request   i_mode, i_position, i_item_value            accepted when start && !busy
// result    o_read_value, o_status, o_count             shown one cycle, o_valid high
//
// Every request is accepted at a clock edge, and its result is registered and sits on the
// result ports, with o_valid high, in the cycle after it. busy is always low, so a new
// request may be issued in every cycle; the row of cells shifts all entries at once.
// Reset empties the list by clearing the count; the entry cells are not cleared.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module indexed_sequence_store_top #(
    parameter int CAPACITY = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [iss_pkg::MODE_W-1:0]         i_mode,
    input  logic [iss_pkg::POS_W-1:0]          i_position,
    input  logic signed [iss_pkg::DATA_W-1:0]  i_item_value,
    output logic                               o_valid,
    output logic signed [iss_pkg::DATA_W-1:0]  o_read_value,
    output logic [iss_pkg::STATUS_W-1:0]       o_status,
    output logic [iss_pkg::COUNT_W-1:0]        o_count
);
    import iss_pkg::*;

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int CW = (IW > POS_W) ? IW : POS_W;
    localparam int RN = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [IW-1:0]     r_count;
    logic [IW-1:0]     n_count;
    logic              r_valid;
    logic [DATA_W-1:0] r_read_value;
    logic [STATUS_W-1:0] r_status;
    logic [COUNT_W-1:0]  r_count_out;

    logic [DATA_W-1:0] w_entries [CAPACITY];
    logic [DATA_W-1:0] w_read;
    logic [DATA_W-1:0] n_read_value;
    logic [STATUS_W-1:0] n_status;
    logic [CW-1:0]     w_count_c;
    logic [CW-1:0]     w_pos_c;
    logic [CW-1:0]     w_target;
    t_cell_cmd         w_cmd;
    logic              w_accept;

    assign busy      = 1'b0;
    assign w_accept  = start && !busy;
    assign w_count_c = CW'(r_count);
    assign w_pos_c   = CW'(i_position);

    // Only the first RN cells (CAPACITY, but at most 2**POS_W) can be addressed by a position.
    always_comb begin
        w_read = '0;
        for (int k = 0; k < RN; k++) begin
            if (i_position == POS_W'(k)) begin
                w_read = w_entries[k];
            end
        end
    end

    always_comb begin
        n_count      = r_count;
        n_status     = ST_OK;
        n_read_value = NO_VALUE;
        w_cmd.op     = CELL_HOLD;
        w_cmd.value  = i_item_value;
        w_target     = w_pos_c;
        case (i_mode)
            MODE_INSERT: begin
                if (w_pos_c > w_count_c) begin
                    n_status = ST_BAD_INDEX;
                end else if (w_count_c >= CAP_C) begin
                    n_status = ST_FULL;
                end else begin
                    w_cmd.op = CELL_OPEN;
                    n_count  = r_count + IW'(1);
                end
            end
            MODE_READ: begin
                if (w_pos_c >= w_count_c || w_pos_c >= CAP_C) begin
                    n_status = ST_BAD_INDEX;
                end else begin
                    n_read_value = w_read;
                end
            end
            MODE_DELETE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (w_pos_c >= w_count_c) begin
                    n_status = ST_BAD_INDEX;
                end else begin
                    w_cmd.op = CELL_CLOSE;
                    n_count  = r_count - IW'(1);
                end
            end
            MODE_APPEND: begin
                w_target = w_count_c;
                if (w_count_c >= CAP_C) begin
                    n_status = ST_FULL;
                end else begin
                    w_cmd.op = CELL_LOAD;
                    n_count  = r_count + IW'(1);
                end
            end
            MODE_DELETE_LAST: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - IW'(1);
                end
            end
            default: begin
                n_status = ST_BAD_INDEX;
            end
        endcase
        if (!w_accept) begin
            w_cmd.op = CELL_HOLD;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_W-1:0] w_left;
            logic [DATA_W-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_inner_l
                assign w_left = w_entries[g-1];
            end
            // The top cell has nothing above it to pull down; it keeps its value.
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = w_entries[g];
            end else begin : g_inner_r
                assign w_right = w_entries[g+1];
            end
            iss_cell #(
                .CW    (CW),
                .INDEX (g)
            ) u_cell (
                .i_clk    (i_clk),
                .i_cmd    (w_cmd),
                .i_target (w_target),
                .i_left   (w_left),
                .i_right  (w_right),
                .o_entry  (w_entries[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
        if (w_accept) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
            r_count_out  <= COUNT_W'(CW'(n_count));
        end
    end

    assign o_valid      = r_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count      = r_count_out;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import iss_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int WATCHDOG   = 2000;
    localparam int PHASE_ITEMS = 520;

    // Modes that the block does not define; they must answer as a bad index.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0]   read_value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_list_answer;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [MODE_W-1:0]         i_mode;
    logic [POS_W-1:0]          i_position;
    logic signed [DATA_W-1:0]  i_item_value;
    logic                      o_valid;
    logic signed [DATA_W-1:0]  o_read_value;
    logic [STATUS_W-1:0]       o_status;
    logic [COUNT_W-1:0]        o_count;

    // Shadow copy of the list as the block should hold it.
    logic [DATA_W-1:0] cells [CAPACITY];
    int                held = 0;

    t_list_answer pending_answers[$];
    int           mismatches = 0;
    int           send_idle_pct = 34;
    int           idle_cycles = 0;
    int           mode_seen [8];
    int           full_seen = 0;
    int           requests_sent = 0;

    indexed_sequence_store_top #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_mode(i_mode),
        .i_position(i_position),
        .i_item_value(i_item_value),
        .o_valid(o_valid),
        .o_read_value(o_read_value),
        .o_status(o_status),
        .o_count(o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_list_answer apply_request(logic [MODE_W-1:0] mode,
                                                   logic [POS_W-1:0] pos,
                                                   logic [DATA_W-1:0] val);
        t_list_answer ans;
        int i;
        ans.read_value = NO_VALUE;
        ans.status     = ST_OK;
        case (mode)
            MODE_INSERT: begin
                // The index check wins over the full check.
                if (pos > held) begin
                    ans.status = ST_BAD_INDEX;
                end else if (held >= CAPACITY) begin
                    ans.status = ST_FULL;
                end else begin
                    for (i = held; i > pos; i--)
                        cells[i] = cells[i-1];
                    cells[pos] = val;
                    held++;
                end
            end
            MODE_READ: begin
                if (pos >= held)
                    ans.status = ST_BAD_INDEX;
                else
                    ans.read_value = cells[pos];
            end
            MODE_DELETE: begin
                // An empty list is reported before the index is looked at.
                if (held == 0) begin
                    ans.status = ST_EMPTY;
                end else if (pos >= held) begin
                    ans.status = ST_BAD_INDEX;
                end else begin
                    for (i = pos; i + 1 < held; i++)
                        cells[i] = cells[i+1];
                    held--;
                end
            end
            MODE_APPEND: begin
                if (held >= CAPACITY) begin
                    ans.status = ST_FULL;
                end else begin
                    cells[held] = val;
                    held++;
                end
            end
            MODE_DELETE_LAST: begin
                if (held == 0)
                    ans.status = ST_EMPTY;
                else
                    held--;
            end
            default: begin
                ans.status = ST_BAD_INDEX;
            end
        endcase
        ans.count = held[COUNT_W-1:0];
        return ans;
    endfunction

    task automatic log_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
        t_list_answer ans;
        if ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge i_clk);
        end
        start        <= 1'b1;
        i_mode       <= mode;
        i_position   <= pos;
        i_item_value <= val;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        ans = apply_request(mode, pos, val);
        pending_answers.push_back(ans);
        mode_seen[mode]++;
        if (ans.status == ST_FULL)
            full_seen++;
        requests_sent++;
    endtask

    task automatic wait_for_answers();
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_list();
        send_request(MODE_READ, 5'd0, '0);
        send_request(MODE_READ, 5'd16, '0);
        send_request(MODE_DELETE, 5'd0, '0);
        send_request(MODE_DELETE, 5'd16, '0);
        send_request(MODE_DELETE_LAST, 5'd0, '0);
        send_request(MODE_INSERT, 5'd1, 32'h1234_5678);
    endtask

    task automatic test_basic_edits();
        send_request(MODE_INSERT, 5'd0, 32'h7FFF_FFFF);
        send_request(MODE_APPEND, 5'd31, 32'h8000_0000);
        send_request(MODE_INSERT, 5'd2, 32'h0000_0000);
        send_request(MODE_INSERT, 5'd1, 32'hFFFF_FFFF);
        send_request(MODE_READ, 5'd0, '0);
        send_request(MODE_READ, 5'd1, '0);
        send_request(MODE_READ, 5'd2, '0);
        send_request(MODE_READ, 5'd3, '0);
        send_request(MODE_READ, 5'd4, '0);
        send_request(MODE_INSERT, 5'd5, 32'h5555_5555);
        send_request(MODE_DELETE, 5'd4, '0);
        send_request(MODE_DELETE, 5'd1, '0);
        send_request(MODE_DELETE, 5'd0, '0);
        send_request(MODE_READ, 5'd0, '0);
        send_request(MODE_DELETE_LAST, 5'd0, 32'hAAAA_AAAA);
        for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
            send_request(m[MODE_W-1:0], 5'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_full_list();
        int k;
        while (held < CAPACITY) begin
            if ($urandom_range(1) == 0)
                send_request(MODE_APPEND, POS_W'($urandom_range(31)), pick_value());
            else
                send_request(MODE_INSERT, POS_W'($urandom_range(held)), pick_value());
        end
        send_request(MODE_INSERT, 5'd16, 32'h0BAD_0BAD);
        send_request(MODE_INSERT, 5'd17, 32'h0BAD_0BAD);
        send_request(MODE_APPEND, 5'd0, 32'h0BAD_0BAD);
        for (k = 0; k <= CAPACITY; k++)
            send_request(MODE_READ, k[POS_W-1:0], '0);
        send_request(MODE_DELETE, 5'd15, '0);
        send_request(MODE_INSERT, 5'd16, 32'h0BAD_0BAD);
        while (held > 0) begin
            send_request(MODE_READ, POS_W'(held - 1), '0);
            send_request(MODE_DELETE_LAST, POS_W'($urandom_range(31)), '0);
        end
        send_request(MODE_DELETE_LAST, 5'd0, '0);
    endtask

    // Walks the fill level up and down so that full and empty are both visited often.
    task automatic test_random_phase(input int idle_pct, input int items);
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pos;
        bit growing;
        int roll;
        int pick;
        send_idle_pct = idle_pct;
        growing = 1'b1;
        repeat (items) begin
            if (held == CAPACITY && $urandom_range(3) == 0)
                growing = 1'b0;
            if (held == 0)
                growing = 1'b1;
            if ($urandom_range(49) == 0)
                growing = !growing;
            roll = $urandom_range(99);
            if (roll < 3)
                mode = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
            else if (growing)
                mode = roll < 45 ? MODE_INSERT : roll < 70 ? MODE_APPEND :
                       roll < 85 ? MODE_READ : roll < 93 ? MODE_DELETE : MODE_DELETE_LAST;
            else
                mode = roll < 12 ? MODE_INSERT : roll < 20 ? MODE_APPEND :
                       roll < 40 ? MODE_READ : roll < 75 ? MODE_DELETE : MODE_DELETE_LAST;
            pick = $urandom_range(9);
            if (pick < 7) begin
                if (mode != MODE_INSERT && held > 0)
                    pos = POS_W'($urandom_range(held - 1));
                else
                    pos = POS_W'($urandom_range(held));
            end else if (pick < 9) begin
                pos = POS_W'($urandom_range(CAPACITY));
            end else begin
                pos = POS_W'($urandom_range(31));
            end
            send_request(mode, pos, pick_value());
        end
        wait_for_answers();
    endtask

    always @(posedge i_clk) begin
        t_list_answer want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_answers.size() == 0) begin
                log_mismatch("result with no request outstanding");
            end else begin
                want = pending_answers.pop_front();
                if (o_read_value !== want.read_value)
                    log_mismatch($sformatf("read_value %h, expected %h",
                                           o_read_value, want.read_value));
                if (o_status !== want.status)
                    log_mismatch($sformatf("status %0d, expected %0d", o_status, want.status));
                if (o_count !== want.count)
                    log_mismatch($sformatf("count %0d, expected %0d", o_count, want.count));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Watchdog: nothing accepted for %0d cycles", WATCHDOG);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_mode       <= MODE_READ;
        i_position   <= '0;
        i_item_value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_basic_edits();
        wait_for_answers();
        test_full_list();
        wait_for_answers();
        test_random_phase(34, PHASE_ITEMS);
        test_random_phase(77, PHASE_ITEMS);
        test_random_phase(0, PHASE_ITEMS);

        wait_for_answers();
        repeat (4) @(posedge i_clk);
        $display("Covered %0d requests: %0d insert, %0d read, %0d delete, %0d append, %0d pop",
                 requests_sent, mode_seen[MODE_INSERT], mode_seen[MODE_READ],
                 mode_seen[MODE_DELETE], mode_seen[MODE_APPEND], mode_seen[MODE_DELETE_LAST]);
        $display("Unused modes sent %0d times; full list refused %0d requests",
                 mode_seen[5] + mode_seen[6] + mode_seen[7], full_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
